// File: hdl/iis_pkg.sv
// Package for the integral image stream unit: sizes, register indexes,
// frame size clamping and the item record passed from sequencer to accumulator.
// Depends on nothing.
package iis_pkg;

	localparam int MAX_COLS = 2048;
	localparam int MAX_ROWS = 2048;

	localparam int PIX_W   = 8;
	localparam int CFG_W   = 12;
	localparam int AREA_W  = 30;
	localparam int STORE_W = 31;

	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int COLS_W = $clog2(MAX_COLS + 1);
	localparam int ROWS_W = $clog2(MAX_ROWS + 1);
	localparam int RUN_W  = $clog2(MAX_COLS * ((1 << PIX_W) - 1) + 1);

	localparam int IDX_W = 1;
	localparam logic [IDX_W-1:0] REG_FRAME_COLS = 1'b0;
	localparam logic [IDX_W-1:0] REG_FRAME_ROWS = 1'b1;

	localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 12'd2048;

	function automatic logic [COLS_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
		if (v == '0) begin
			return COLS_W'(1);
		end else if (int'(v) > MAX_COLS) begin
			return COLS_W'(MAX_COLS);
		end else begin
			return COLS_W'(v);
		end
	endfunction

	function automatic logic [ROWS_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
		if (v == '0) begin
			return ROWS_W'(1);
		end else if (int'(v) > MAX_ROWS) begin
			return ROWS_W'(MAX_ROWS);
		end else begin
			return ROWS_W'(v);
		end
	endfunction

	typedef struct packed {
		logic             valid;
		logic [RUN_W-1:0] run_sum;
		logic [COL_W-1:0] col;
		logic             first_row;
		logic             frame_end;
	} iis_item_t;

endpackage

// File: hdl/iis_pixel_if.sv
// Input channel of the integral image stream unit: one pixel per item.
// Depends on iis_pkg.
interface iis_pixel_if;
	logic                      valid;
	logic                      ready;
	logic [iis_pkg::PIX_W-1:0] pixel;

	modport source(output valid, output pixel, input ready);
	modport sink(input valid, input pixel, output ready);
endinterface

// File: hdl/iis_result_if.sv
// Output channel of the integral image stream unit: one area sum per item.
// Depends on iis_pkg.
interface iis_result_if;
	logic                       valid;
	logic                       ready;
	logic [iis_pkg::AREA_W-1:0] area_sum;
	logic                       frame_end;

	modport source(output valid, output area_sum, output frame_end, input ready);
	modport sink(input valid, input area_sum, input frame_end, output ready);
endinterface

// File: hdl/iis_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module iis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/iis_sequencer.sv
// Frame size registers, column and row counters and the running row sum.
// Depends on iis_pkg and iis_pixel_if.
module iis_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [iis_pkg::IDX_W-1:0]       cfg_index,
	input  logic [iis_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            s1_free,
	iis_pixel_if.sink                       pixels,
	output iis_pkg::iis_item_t              item
);

	logic [iis_pkg::COLS_W-1:0] cols_q;
	logic [iis_pkg::ROWS_W-1:0] rows_q;
	logic [iis_pkg::COL_W-1:0]  col_q;
	logic [iis_pkg::ROW_W-1:0]  row_q;
	logic [iis_pkg::RUN_W-1:0]  run_q;

	logic                       accept;
	logic [iis_pkg::COLS_W-1:0] col_inc;
	logic [iis_pkg::ROWS_W-1:0] row_inc;
	logic                       last_col;
	logic                       last_row;
	logic [iis_pkg::RUN_W-1:0]  run_new;

	assign pixels.ready = s1_free;
	assign accept       = pixels.valid && s1_free;

	assign col_inc  = iis_pkg::COLS_W'(col_q) + iis_pkg::COLS_W'(1);
	assign row_inc  = iis_pkg::ROWS_W'(row_q) + iis_pkg::ROWS_W'(1);
	assign last_col = col_inc >= cols_q;
	assign last_row = row_inc >= rows_q;
	assign run_new  = run_q + iis_pkg::RUN_W'(pixels.pixel);

	always_comb begin
		item.valid     = accept;
		item.run_sum   = run_new;
		item.col       = col_q;
		item.first_row = (row_q == '0);
		item.frame_end = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= iis_pkg::clamp_cols(iis_pkg::CFG_SIZE_RESET);
			rows_q <= iis_pkg::clamp_rows(iis_pkg::CFG_SIZE_RESET);
			col_q  <= '0;
			row_q  <= '0;
			run_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					iis_pkg::REG_FRAME_COLS: cols_q <= iis_pkg::clamp_cols(cfg_data);
					iis_pkg::REG_FRAME_ROWS: rows_q <= iis_pkg::clamp_rows(cfg_data);
					default: ;
				endcase
			end
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					run_q <= '0;
					row_q <= last_row ? '0 : iis_pkg::ROW_W'(row_inc);
				end else begin
					col_q <= iis_pkg::COL_W'(col_inc);
					run_q <= run_new;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.frame_end |=> col_q == '0 && row_q == '0)
		else $error("counters did not return to zero after the last item of a frame");

	a_size_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cols_q != '0 && rows_q != '0)
		else $error("effective frame size is zero");
`endif

endmodule

// File: hdl/iis_accum.sv
// Line store read-modify-write with forwarding, fill count and output register.
// Depends on iis_pkg, iis_result_if and iis_ram.
module iis_accum (
	input  logic               clk,
	input  logic               arst_n,
	input  iis_pkg::iis_item_t item,
	output logic               s1_free,
	iis_result_if.source       results
);

	logic                        v_s1;
	logic [iis_pkg::RUN_W-1:0]   run_s1;
	logic [iis_pkg::COL_W-1:0]   col_s1;
	logic                        first_s1;
	logic                        end_s1;
	logic                        fwd_s1;
	logic [iis_pkg::STORE_W-1:0] fwd_data_s1;

	logic                        out_v_q;
	logic [iis_pkg::AREA_W-1:0]  area_q;
	logic                        end_q;
	logic [iis_pkg::COLS_W-1:0]  fill_q;

	logic [iis_pkg::STORE_W-1:0] rdata;
	logic [iis_pkg::STORE_W-1:0] above;
	logic [iis_pkg::STORE_W-1:0] sum_s1;
	logic                        s1_fire;
	logic                        entry_valid;

	iis_ram #(
		.WIDTH(iis_pkg::STORE_W),
		.DEPTH(iis_pkg::MAX_COLS)
	) u_line_store (
		.clk   (clk),
		.we    (s1_fire),
		.waddr (col_s1),
		.wdata (sum_s1),
		.re    (item.valid),
		.raddr (item.col),
		.rdata (rdata)
	);

	assign entry_valid = iis_pkg::COLS_W'(col_s1) < fill_q;

	always_comb begin
		if (first_s1) begin
			above = '0;
		end else if (fwd_s1) begin
			above = fwd_data_s1;
		end else if (entry_valid) begin
			above = rdata;
		end else begin
			above = '0;
		end
	end

	assign sum_s1  = above + iis_pkg::STORE_W'(run_s1);
	assign s1_fire = v_s1 && (!out_v_q || results.ready);
	assign s1_free = !v_s1 || s1_fire;

	assign results.valid     = out_v_q;
	assign results.area_sum  = area_q;
	assign results.frame_end = end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
			fill_q  <= '0;
		end else begin
			if (s1_free) begin
				v_s1 <= item.valid;
			end
			if (s1_fire) begin
				out_v_q <= 1'b1;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
			if (s1_fire && iis_pkg::COLS_W'(col_s1) == fill_q) begin
				fill_q <= fill_q + iis_pkg::COLS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid) begin
			run_s1      <= item.run_sum;
			col_s1      <= item.col;
			first_s1    <= item.first_row;
			end_s1      <= item.frame_end;
			fwd_s1      <= v_s1 && (col_s1 == item.col);
			fwd_data_s1 <= sum_s1;
		end
		if (s1_fire) begin
			area_q <= sum_s1[iis_pkg::AREA_W-1:0];
			end_q  <= end_s1;
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= iis_pkg::MAX_COLS)
		else $error("line store fill count beyond its depth");

	a_write_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |-> iis_pkg::COLS_W'(col_s1) <= fill_q)
		else $error("line store write leaves a gap above the filled entries");

	a_fwd_live: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && fwd_s1 |-> col_s1 == '0)
		else $error("forwarded sum on an item outside column zero");
`endif

endmodule

// File: hdl/integral_image_stream_unit.sv
// Integral image stream unit: top level tying the sequencer to the accumulator.
// Depends on iis_pkg, iis_pixel_if, iis_result_if, iis_sequencer and iis_accum.
//
// The unit takes one 8-bit pixel per clock in raster order unless stalled and returns,
// for each one, the sum of all pixels of the frame above, to the left of and at that
// position. Items flow back to back at one per cycle unless stalled, and the output
// register lets a new pixel in while a result waits. The rate is set by the single
// line store, which is read and written once per pixel; when a row is only one column
// wide the value just written is forwarded to the next read. There is no clearing pass
// after reset: a fill count marks which line store entries hold data, and the first
// row of every frame reads the line store as zero. The user must write frame size
// registers only while the unit is idle, unenforced; a size of zero acts as one.
module integral_image_stream_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [iis_pkg::IDX_W-1:0] cfg_index,
	input  logic [iis_pkg::CFG_W-1:0] cfg_data,
	iis_pixel_if.sink                 pixels,
	iis_result_if.source              results
);

	iis_pkg::iis_item_t item;
	logic               s1_free;

	iis_sequencer u_sequencer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s1_free   (s1_free),
		.pixels    (pixels),
		.item      (item)
	);

	iis_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.s1_free (s1_free),
		.results (results)
	);

endmodule
